/* src/mpr_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpr_pkg
// Shared widths, register indexes and reset values of the masked pixel to
// RGB888 converter.
// ----------------------------------------------------------------------------
package mpr_pkg;

	localparam int RAW_W      = 32;
	localparam int WORD_W     = 32;
	localparam int MASK_W     = 32;
	localparam int QUOT_W     = 8;
	localparam int NUM_W      = MASK_W + QUOT_W;
	localparam int CHAN_N     = 3;
	localparam int BPP_W      = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int STAGES     = 2 + QUOT_W;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [MASK_W-1:0] mask_t;
	typedef logic [NUM_W-1:0]  num_t;
	typedef logic [QUOT_W-1:0] quot_t;

	localparam logic [CFG_IDX_W-1:0] REG_BPP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RMASK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GMASK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BMASK = 3'd4;

	localparam logic [BPP_W-1:0] BPP_RST   = 3'd4;
	localparam logic             LE_RST    = 1'b1;
	localparam mask_t            RMASK_RST = 32'h00FF_0000;
	localparam mask_t            GMASK_RST = 32'h0000_FF00;
	localparam mask_t            BMASK_RST = 32'h0000_00FF;

endpackage
`default_nettype wire

/* src/masked_pixel_to_rgb888_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// masked_pixel_to_rgb888_core
// Converts one raw pixel of 1 to 4 bytes into an RGB888 triple using three
// configurable channel masks, with rounded scaling to 0..255.
//
// Pixel channel: raw_bytes with pix_valid / pix_stall. Result channel: red,
// green, blue with rgb_valid / rgb_stall. An item moves on a clock edge with
// valid high and stall low.
// Configuration: cfg_we, cfg_index, cfg_wdata; write only while no item is
// in flight. Index 0 bytes per pixel, 1 little endian, 2..4 red, green and
// blue masks. Unknown indexes are ignored.
// The pipeline stages are byte assembly, dividend build, then one register
// stage per quotient bit of the 8-step restoring divider.
// Throughput is one item per cycle while rgb_stall is low; every stage carries its own valid bit
// and advances whenever the stage behind it is free.
// When rgb_stall is high the result holds and the pipeline keeps filling
// its empty stages; pix_stall rises once every stage is occupied.
// Reset clears all valid bits and loads the default XRGB8888 settings:
// 4 bytes, little endian, masks 0x00FF0000, 0x0000FF00, 0x000000FF.
// ----------------------------------------------------------------------------
module masked_pixel_to_rgb888_core
	import mpr_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  pix_valid,
	output logic                       pix_stall,
	input  wire logic [RAW_W-1:0]      raw_bytes,
	output logic                       rgb_valid,
	input  wire logic                  rgb_stall,
	output logic [7:0]                 red,
	output logic [7:0]                 green,
	output logic [7:0]                 blue
);

	logic [BPP_W-1:0] bpp_q;
	logic             le_q;
	mask_t            mask_q [CHAN_N];

	logic [STAGES-1:0] vld_q;
	logic [STAGES:0]   rdy;

	word_t word_s1;
	num_t  rem_a  [CHAN_N][QUOT_W];
	quot_t quot_a [CHAN_N][QUOT_W+1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q     <= BPP_RST;
			le_q      <= LE_RST;
			mask_q[0] <= RMASK_RST;
			mask_q[1] <= GMASK_RST;
			mask_q[2] <= BMASK_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BPP:   bpp_q     <= cfg_wdata[BPP_W-1:0];
				REG_LE:    le_q      <= cfg_wdata[0];
				REG_RMASK: mask_q[0] <= cfg_wdata[MASK_W-1:0];
				REG_GMASK: mask_q[1] <= cfg_wdata[MASK_W-1:0];
				REG_BMASK: mask_q[2] <= cfg_wdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// stage flow control
	assign rdy[STAGES] = !rgb_stall;
	for (genvar k = 0; k < STAGES; k++) begin : g_rdy
		assign rdy[k] = !vld_q[k] || rdy[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= (k == 0) ? pix_valid : vld_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign pix_stall = !rdy[0];
	assign rgb_valid = vld_q[STAGES-1];

	mpr_word_asm u_asm (
		.clk             (clk),
		.en              (rdy[0]),
		.raw_bytes       (raw_bytes),
		.bytes_per_pixel (bpp_q),
		.little_endian   (le_q),
		.word_s1         (word_s1)
	);

	for (genvar c = 0; c < CHAN_N; c++) begin : g_chan
		mpr_num_prep u_prep (
			.clk    (clk),
			.en     (rdy[1]),
			.word   (word_s1),
			.mask   (mask_q[c]),
			.num_s2 (rem_a[c][0])
		);

		assign quot_a[c][0] = '0;

		for (genvar j = 0; j < QUOT_W; j++) begin : g_step
			if (j == QUOT_W-1) begin : g_last
				mpr_div_step #(
					.BIT (QUOT_W-1-j)
				) u_step (
					.clk     (clk),
					.en      (rdy[2+j]),
					.mask    (mask_q[c]),
					.rem_in  (rem_a[c][j]),
					.quot_in (quot_a[c][j]),
					.rem_s   (),
					.quot_s  (quot_a[c][j+1])
				);
			end else begin : g_mid
				mpr_div_step #(
					.BIT (QUOT_W-1-j)
				) u_step (
					.clk     (clk),
					.en      (rdy[2+j]),
					.mask    (mask_q[c]),
					.rem_in  (rem_a[c][j]),
					.quot_in (quot_a[c][j]),
					.rem_s   (rem_a[c][j+1]),
					.quot_s  (quot_a[c][j+1])
				);
			end
		end
	end

	assign red   = quot_a[0][QUOT_W];
	assign green = quot_a[1][QUOT_W];
	assign blue  = quot_a[2][QUOT_W];

endmodule
`default_nettype wire

/* src/mpr_word_asm.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpr_word_asm
// First stage: gathers the valid bytes of a raw pixel into a pixel word in
// the configured byte order.
// ----------------------------------------------------------------------------
module mpr_word_asm
	import mpr_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [RAW_W-1:0] raw_bytes,
	input  wire logic [BPP_W-1:0] bytes_per_pixel,
	input  wire logic             little_endian,
	output word_t                 word_s1
);

	word_t word_le;
	word_t word_be;

	always_comb begin
		unique case (bytes_per_pixel)
			3'd0: begin
				word_le = '0;
				word_be = '0;
			end
			3'd1: begin
				word_le = {24'd0, raw_bytes[7:0]};
				word_be = {24'd0, raw_bytes[7:0]};
			end
			3'd2: begin
				word_le = {16'd0, raw_bytes[15:0]};
				word_be = {16'd0, raw_bytes[7:0], raw_bytes[15:8]};
			end
			3'd3: begin
				word_le = {8'd0, raw_bytes[23:0]};
				word_be = {8'd0, raw_bytes[7:0], raw_bytes[15:8], raw_bytes[23:16]};
			end
			default: begin
				word_le = raw_bytes;
				word_be = {raw_bytes[7:0], raw_bytes[15:8], raw_bytes[23:16],
					raw_bytes[31:24]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= little_endian ? word_le : word_be;
		end
	end

endmodule
`default_nettype wire

/* src/mpr_num_prep.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpr_num_prep
// Second stage: builds the rounding dividend of one channel,
// (word & mask) * 255 + half, kept at the mask's bit position.
// ----------------------------------------------------------------------------
module mpr_num_prep
	import mpr_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  en,
	input  wire word_t word,
	input  wire mask_t mask,
	output num_t       num_s2
);

	num_t fld;
	num_t half;

	// half of the shifted-down maximum, moved back up to the mask position
	assign fld  = {{(NUM_W-MASK_W){1'b0}}, word & mask};
	assign half = {{(NUM_W-MASK_W){1'b0}}, (mask & (mask - 1'b1)) >> 1};

	always_ff @(posedge clk) begin
		if (en) begin
			num_s2 <= (fld << QUOT_W) - fld + half;
		end
	end

endmodule
`default_nettype wire

/* src/mpr_div_step.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mpr_div_step
// One restoring division stage: decides one quotient bit of
// dividend / mask and passes the partial remainder on.
// ----------------------------------------------------------------------------
module mpr_div_step
	import mpr_pkg::*;
#(
	parameter int BIT = 0
) (
	input  wire logic  clk,
	input  wire logic  en,
	input  wire mask_t mask,
	input  wire num_t  rem_in,
	input  wire quot_t quot_in,
	output num_t       rem_s,
	output quot_t      quot_s
);

	num_t  dsh;
	logic  take;
	quot_t quot_nxt;

	assign dsh  = {{(NUM_W-MASK_W){1'b0}}, mask} << BIT;
	// zero mask never sets a bit, so the channel reads 0
	assign take = (mask != '0) && (rem_in >= dsh);

	always_comb begin
		quot_nxt      = quot_in;
		quot_nxt[BIT] = take;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s  <= take ? rem_in - dsh : rem_in;
			quot_s <= quot_nxt;
		end
	end

endmodule
`default_nettype wire
